// File: hdl/fon_pkg.sv
// ----------------------------------------------------------------------------
// Face orientation normalizer package
// Shared constants and the fixed orientation and permutation tables.
// ----------------------------------------------------------------------------
package fon_pkg;

    localparam int NODE_ID_BITS_DEF = 32;
    localparam int FACE_NODES       = 4;
    localparam int TRI_NODES        = 3;
    localparam int FLAG_BITS        = 5;
    localparam int POS_BITS         = 2;

    typedef logic [FLAG_BITS-1:0] flag_t;
    typedef logic [POS_BITS-1:0]  pos_t;

    // Orientation flag of a quad, indexed by the source positions of the three
    // smallest nodes. Unused keys hold 31.
    localparam flag_t QUAD_FLAG [FACE_NODES][FACE_NODES][FACE_NODES] = '{
        '{ '{5'd31, 5'd31, 5'd31, 5'd31}, '{5'd31, 5'd31, 5'd7,  5'd23},
           '{5'd31, 5'd15, 5'd31, 5'd11}, '{5'd31, 5'd19, 5'd3,  5'd31} },
        '{ '{5'd31, 5'd31, 5'd22, 5'd6},  '{5'd31, 5'd31, 5'd31, 5'd31},
           '{5'd18, 5'd31, 5'd31, 5'd2},  '{5'd14, 5'd31, 5'd10, 5'd31} },
        '{ '{5'd31, 5'd8,  5'd31, 5'd12}, '{5'd0,  5'd31, 5'd31, 5'd16},
           '{5'd31, 5'd31, 5'd31, 5'd31}, '{5'd4,  5'd20, 5'd31, 5'd31} },
        '{ '{5'd31, 5'd1,  5'd17, 5'd31}, '{5'd9,  5'd31, 5'd13, 5'd31},
           '{5'd21, 5'd5,  5'd31, 5'd31}, '{5'd31, 5'd31, 5'd31, 5'd31} }
    };

    // Orientation flag of a triangle, indexed by the source positions of the
    // two smallest nodes.
    localparam flag_t TRI_FLAG [TRI_NODES][TRI_NODES] = '{
        '{5'd31, 5'd4,  5'd0},
        '{5'd1,  5'd31, 5'd6},
        '{5'd5,  5'd2,  5'd31}
    };

    // Permutations, indexed by the low three bits of the flag.
    localparam pos_t QUAD_PERM [8][FACE_NODES] = '{
        '{2'd2, 2'd1, 2'd0, 2'd3}, '{2'd3, 2'd0, 2'd1, 2'd2},
        '{2'd1, 2'd2, 2'd3, 2'd0}, '{2'd0, 2'd3, 2'd2, 2'd1},
        '{2'd2, 2'd3, 2'd0, 2'd1}, '{2'd3, 2'd2, 2'd1, 2'd0},
        '{2'd1, 2'd0, 2'd3, 2'd2}, '{2'd0, 2'd1, 2'd2, 2'd3}
    };

    localparam pos_t TRI_PERM [8][TRI_NODES] = '{
        '{2'd0, 2'd2, 2'd1}, '{2'd1, 2'd0, 2'd2},
        '{2'd2, 2'd1, 2'd0}, '{2'd0, 2'd1, 2'd2},
        '{2'd0, 2'd1, 2'd2}, '{2'd2, 2'd0, 2'd1},
        '{2'd1, 2'd2, 2'd0}, '{2'd0, 2'd1, 2'd2}
    };

endpackage

// File: hdl/fon_rank.sv
// ----------------------------------------------------------------------------
// Face orientation normalizer: ranking and flag lookup
// Stable ranking of the face nodes and lookup of the orientation flag.
// ----------------------------------------------------------------------------
module fon_rank
    import fon_pkg::*;
#(
    parameter int NODE_ID_BITS = NODE_ID_BITS_DEF
)
(
    input  logic                    is_quad,
    input  logic [NODE_ID_BITS-1:0] node [FACE_NODES],
    output flag_t                   flag
);

    logic ahead [FACE_NODES][FACE_NODES];
    logic used  [FACE_NODES];
    pos_t rank  [FACE_NODES];
    pos_t src   [TRI_NODES];
    pos_t tri_a;
    pos_t tri_b;

    // ahead[j][i] is set when position j sorts in front of position i. Ties go
    // to the lower position, which keeps the sort stable.
    always_comb
    begin
        for (int i = 0; i < FACE_NODES; i++)
        begin
            for (int j = 0; j < FACE_NODES; j++)
            begin
                if (j < i)
                    ahead[j][i] = (node[j] <= node[i]);
                else if (j > i)
                    ahead[j][i] = (node[j] < node[i]);
                else
                    ahead[j][i] = 1'b0;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < FACE_NODES; i++)
            used[i] = (i < TRI_NODES) || is_quad;
        for (int i = 0; i < FACE_NODES; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < FACE_NODES; j++)
                rank[i] = rank[i] + pos_t'(ahead[j][i] && used[j]);
        end
        for (int k = 0; k < TRI_NODES; k++)
        begin
            src[k] = '0;
            for (int i = 0; i < FACE_NODES; i++)
            begin
                if (used[i] && rank[i] == pos_t'(k))
                    src[k] = pos_t'(i);
            end
        end
    end

    assign tri_a = (src[0] < pos_t'(TRI_NODES)) ? src[0] : '0;
    assign tri_b = (src[1] < pos_t'(TRI_NODES)) ? src[1] : '0;

    assign flag = is_quad ? QUAD_FLAG[src[0]][src[1]][src[2]] : TRI_FLAG[tri_a][tri_b];

endmodule

// File: hdl/fon_permute.sv
// ----------------------------------------------------------------------------
// Face orientation normalizer: node permutation
// Reorders the face nodes by the permutation that the flag selects.
// ----------------------------------------------------------------------------
module fon_permute
    import fon_pkg::*;
#(
    parameter int NODE_ID_BITS = NODE_ID_BITS_DEF
)
(
    input  logic                    is_quad,
    input  flag_t                   flag,
    input  logic [NODE_ID_BITS-1:0] node     [FACE_NODES],
    output logic [NODE_ID_BITS-1:0] out_node [FACE_NODES]
);

    logic [2:0] perm_sel;

    assign perm_sel = flag[2:0];

    // A triangle overwrites the first three slots; its fourth slot stays zero.
    always_comb
    begin
        for (int k = 0; k < FACE_NODES; k++)
        begin
            if (is_quad)
                out_node[k] = node[QUAD_PERM[perm_sel][k]];
            else
                out_node[k] = '0;
        end
        for (int k = 0; k < TRI_NODES; k++)
        begin
            if (!is_quad)
                out_node[k] = node[TRI_PERM[perm_sel][k]];
        end
    end

endmodule

// File: hdl/face_orientation_normalizer_core.sv
// ----------------------------------------------------------------------------
// Face orientation normalizer core
// Brings the node list of a triangle or quad face into canonical orientation.
// ----------------------------------------------------------------------------
// Each face transaction is latched into an input register, ranked by a stable
// sort, mapped to a 5-bit orientation flag and reordered, and the result is
// held in an output register. One face is accepted every clock cycle while
// the master side takes results. A face moves from the input register to the
// output register once the output register is free, and these two registers
// are the only ones on its path. Back pressure on the master side stalls the
// pipeline without losing or repeating transactions.
module face_orientation_normalizer_core
    import fon_pkg::*;
#(
    parameter  int NODE_ID_BITS = NODE_ID_BITS_DEF,
    localparam int S_USED       = 1 + FACE_NODES * NODE_ID_BITS,
    localparam int M_USED       = FLAG_BITS + FACE_NODES * NODE_ID_BITS,
    localparam int S_WIDTH      = ((S_USED + 7) / 8) * 8,
    localparam int M_WIDTH      = ((M_USED + 7) / 8) * 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // is_quad, node_0, node_1, node_2, node_3, zero padding
    input  logic [S_WIDTH-1:0]   s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // orientation_flag, out_node_0, out_node_1, out_node_2, out_node_3, zero padding
    output logic [M_WIDTH-1:0]   m_tdata
);

    logic                    in_vld_reg;
    logic                    in_quad_reg;
    logic [NODE_ID_BITS-1:0] in_node_reg [FACE_NODES];
    logic                    out_vld_reg;
    logic                    out_vld_next;
    logic [M_WIDTH-1:0]      out_data_reg;
    logic [M_WIDTH-1:0]      out_data_next;

    logic                    out_free;
    logic                    in_take;
    logic                    in_move;
    flag_t                   flag;
    logic [NODE_ID_BITS-1:0] perm_node [FACE_NODES];

    assign out_free = !out_vld_reg || m_tready;
    assign s_tready = !in_vld_reg || out_free;
    assign in_take  = s_tvalid && s_tready;
    assign in_move  = in_vld_reg && out_free;

    fon_rank #(
        .NODE_ID_BITS (NODE_ID_BITS)
    ) u_rank (
        .is_quad (in_quad_reg),
        .node    (in_node_reg),
        .flag    (flag)
    );

    fon_permute #(
        .NODE_ID_BITS (NODE_ID_BITS)
    ) u_permute (
        .is_quad  (in_quad_reg),
        .flag     (flag),
        .node     (in_node_reg),
        .out_node (perm_node)
    );

    always_comb
    begin
        out_data_next = '0;
        out_data_next[FLAG_BITS-1:0] = flag;
        for (int k = 0; k < FACE_NODES; k++)
            out_data_next[FLAG_BITS + k*NODE_ID_BITS +: NODE_ID_BITS] = perm_node[k];
        if (in_move)
            out_vld_next = 1'b1;
        else if (m_tready)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_vld_reg <= s_tvalid;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_quad_reg <= s_tdata[0];
            for (int k = 0; k < FACE_NODES; k++)
                in_node_reg[k] <= s_tdata[1 + k*NODE_ID_BITS +: NODE_ID_BITS];
        end
        if (in_move)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule
